[rtl/tthx_pkg.sv]
// ----------------------------------------------------------------------------
// tthx_pkg
// Shared constants, point numbering, corner order table and lane control
// types for the tetrahedron to four hexahedra split.
// ----------------------------------------------------------------------------
`default_nettype none

package tthx_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_VERTS       = 4;
    localparam int NUM_POINTS      = 15;
    localparam int PT_W            = 4;
    localparam int CORNERS_PER_TET = 32;
    localparam int CNT_W           = 5;

    // Point numbering: vertices, edge midpoints, face centroids, body centroid
    localparam logic [PT_W-1:0] P_V0   = 4'd0;
    localparam logic [PT_W-1:0] P_V1   = 4'd1;
    localparam logic [PT_W-1:0] P_V2   = 4'd2;
    localparam logic [PT_W-1:0] P_V3   = 4'd3;
    localparam logic [PT_W-1:0] P_M01  = 4'd4;
    localparam logic [PT_W-1:0] P_M02  = 4'd5;
    localparam logic [PT_W-1:0] P_M03  = 4'd6;
    localparam logic [PT_W-1:0] P_M12  = 4'd7;
    localparam logic [PT_W-1:0] P_M13  = 4'd8;
    localparam logic [PT_W-1:0] P_M23  = 4'd9;
    localparam logic [PT_W-1:0] P_F012 = 4'd10;
    localparam logic [PT_W-1:0] P_F013 = 4'd11;
    localparam logic [PT_W-1:0] P_F023 = 4'd12;
    localparam logic [PT_W-1:0] P_F123 = 4'd13;
    localparam logic [PT_W-1:0] P_CEN  = 4'd14;

    // Corner order, indexed by {hex, corner}
    localparam logic [PT_W-1:0] CORNER_TAB [CORNERS_PER_TET] = '{
        P_V0, P_M01, P_F012, P_M02, P_F023, P_M03, P_F013, P_CEN,
        P_V1, P_M12, P_F012, P_M01, P_F013, P_M13, P_F123, P_CEN,
        P_V2, P_M02, P_F012, P_M12, P_F123, P_M23, P_F023, P_CEN,
        P_V3, P_M03, P_F023, P_M23, P_F123, P_M13, P_F013, P_CEN
    };

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_sts;

endpackage

`default_nettype wire

[rtl/tthx_lane.sv]
// ----------------------------------------------------------------------------
// tthx_lane
// One coordinate axis: forms the fifteen points of the split for that axis.
// Midpoints and the body centroid come from one add and shift; the face
// centroids run through four radix-8 divide-by-three units.
// ----------------------------------------------------------------------------
`default_nettype none

module tthx_lane #(
    parameter int COORD_WIDTH = tthx_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tthx_pkg::t_lane_ctl    i_ctl,
    input  logic [COORD_WIDTH-1:0] i_v   [tthx_pkg::NUM_VERTS],
    output tthx_pkg::t_lane_sts    o_sts,
    output logic [COORD_WIDTH-1:0] o_pts [tthx_pkg::NUM_POINTS]
);
    import tthx_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int DIGITS = (W + 4) / 3;
    localparam int DVD_W  = 3 * DIGITS;
    localparam int DCNT_W = $clog2(DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Vertex pairs of the edges and vertex triples of the faces
    localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PB [6] = '{1, 2, 3, 2, 3, 3};
    localparam int FA [4] = '{0, 0, 0, 1};
    localparam int FB [4] = '{1, 1, 2, 2};
    localparam int FC [4] = '{2, 3, 3, 3};

    logic [1:0]        r_state, n_state;
    logic [DCNT_W-1:0] r_cnt;
    logic [1:0]        r_rem [4];
    logic [W-1:0]      r_u   [NUM_VERTS];
    logic [W-1:0]      r_mid [6];
    logic [W-1:0]      r_cen;
    logic [DVD_W-1:0]  r_dvd [4];

    logic [W-1:0]      w_u    [NUM_VERTS];
    logic [W-1:0]      w_mid  [6];
    logic [W-1:0]      w_cen;
    logic [DVD_W-1:0]  w_fsum [4];
    logic [4:0]        w_step [4];
    logic [W-1:0]      w_raw  [NUM_POINTS];

    // One quotient digit of a divide by three: {q[2:0], rem[1:0]}
    function automatic logic [4:0] div3_digit(input logic [4:0] t);
        logic [4:0] rem;
        logic [2:0] q;
        rem = t;
        q   = '0;
        for (int b = 2; b >= 0; b--) begin
            if (rem >= (5'd3 << b)) begin
                rem  = rem - (5'd3 << b);
                q[b] = 1'b1;
            end
        end
        return {q, rem[1:0]};
    endfunction

    // Move to offset binary so floor division works unsigned
    always_comb begin
        for (int k = 0; k < NUM_VERTS; k++) begin
            w_u[k] = {~i_v[k][W-1], i_v[k][W-2:0]};
        end
    end

    // Edge midpoints, face sums and body centroid
    always_comb begin
        logic [W:0]   s2;
        logic [W+1:0] s4;
        s2 = '0;
        for (int e = 0; e < 6; e++) begin
            s2       = {1'b0, w_u[PA[e]]} + {1'b0, w_u[PB[e]]};
            w_mid[e] = s2[W:1];
        end
        for (int f = 0; f < 4; f++) begin
            w_fsum[f] = DVD_W'(w_u[FA[f]]) + DVD_W'(w_u[FB[f]]) + DVD_W'(w_u[FC[f]]);
        end
        s4    = (W+2)'(w_u[0]) + (W+2)'(w_u[1]) + (W+2)'(w_u[2]) + (W+2)'(w_u[3]);
        w_cen = s4[W+1:2];
    end

    // Next digit of each face division
    always_comb begin
        for (int f = 0; f < 4; f++) begin
            w_step[f] = div3_digit({r_rem[f], r_dvd[f][DVD_W-1 -: 3]});
        end
    end

    // Sequence load, divide and hold
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_ctl.start) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == DCNT_W'(DIGITS - 1)) n_state = ST_DONE;
            ST_DONE: if (i_ctl.take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture sums, then shift quotient digits in as dividend digits leave
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.start) begin
            r_u   <= w_u;
            r_mid <= w_mid;
            r_cen <= w_cen;
            r_dvd <= w_fsum;
            r_cnt <= '0;
            for (int f = 0; f < 4; f++) begin
                r_rem[f] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            for (int f = 0; f < 4; f++) begin
                r_dvd[f] <= {r_dvd[f][DVD_W-4:0], w_step[f][4:2]};
                r_rem[f] <= w_step[f][1:0];
            end
        end
    end

    // Gather points and return to two's complement
    always_comb begin
        for (int k = 0; k < NUM_VERTS; k++) w_raw[k] = r_u[k];
        for (int e = 0; e < 6; e++) w_raw[4 + e] = r_mid[e];
        for (int f = 0; f < 4; f++) w_raw[10 + f] = r_dvd[f][W-1:0];
        w_raw[14] = r_cen;
        for (int p = 0; p < NUM_POINTS; p++) begin
            o_pts[p] = {~w_raw[p][W-1], w_raw[p][W-2:0]};
        end
    end

    assign o_sts.idle = (r_state == ST_IDLE);
    assign o_sts.done = (r_state == ST_DONE);

endmodule

`default_nettype wire

[rtl/tthx_merge.sv]
// ----------------------------------------------------------------------------
// tthx_merge
// Joins the three lanes into one point bank and walks the corner table,
// one corner per transfer, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tthx_merge #(
    parameter int COORD_WIDTH = tthx_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [COORD_WIDTH-1:0] i_pts_x [tthx_pkg::NUM_POINTS],
    input  logic [COORD_WIDTH-1:0] i_pts_y [tthx_pkg::NUM_POINTS],
    input  logic [COORD_WIDTH-1:0] i_pts_z [tthx_pkg::NUM_POINTS],
    output logic                   o_free,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [1:0]             o_hex,
    output logic [2:0]             o_corner,
    output logic [COORD_WIDTH-1:0] o_px,
    output logic [COORD_WIDTH-1:0] o_py,
    output logic [COORD_WIDTH-1:0] o_pz,
    output logic                   o_last
);
    import tthx_pkg::*;

    localparam int W = COORD_WIDTH;

    logic [W-1:0]      r_px [NUM_POINTS];
    logic [W-1:0]      r_py [NUM_POINTS];
    logic [W-1:0]      r_pz [NUM_POINTS];
    logic              r_full;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_pos;
    logic [W-1:0]      r_out_x, r_out_y, r_out_z;
    logic              r_out_last;

    logic              w_adv;
    logic              w_end;
    logic [PT_W-1:0]   w_sel;

    assign w_adv = r_full && (!r_out_valid || i_ready);
    assign w_end = (r_cnt == CNT_W'(CORNERS_PER_TET - 1));
    assign w_sel = CORNER_TAB[r_cnt];

    // Bank occupancy and corner counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_full <= 1'b1;
                r_cnt  <= '0;
            end else if (w_adv) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_end) r_full <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the points of one tetrahedron
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= i_pts_x;
            r_py <= i_pts_y;
            r_pz <= i_pts_z;
        end
    end

    // Select the next corner into the output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pos  <= r_cnt;
            r_out_x    <= r_px[w_sel];
            r_out_y    <= r_py[w_sel];
            r_out_z    <= r_pz[w_sel];
            r_out_last <= w_end;
        end
    end

    // Refill the bank in the same cycle the last corner leaves it
    assign o_free   = !r_full || (w_adv && w_end);
    assign o_valid  = r_out_valid;
    assign o_hex    = r_out_pos[4:3];
    assign o_corner = r_out_pos[2:0];
    assign o_px     = r_out_x;
    assign o_py     = r_out_y;
    assign o_pz     = r_out_z;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

[rtl/tet_to_four_hex_split_top.sv]
// ----------------------------------------------------------------------------
// tet_to_four_hex_split_top
// Splits one tetrahedron into four hexahedra and streams their 32 corners.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s (tet)   in    i_s_tvalid / o_s_tready   i_s_tdata: 4 vertices x,y,z
//  m (corner) out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tlast
//
//  One tetrahedron yields 32 corner transfers, one per cycle while o_m_tready
//  holds, so the output walk sets how often a new tetrahedron is taken.
//  Three axis lanes, bound by the radix-8 divide by three, work on the
//  next tetrahedron hidden behind the previous walk.
//  Reset clears control state only; there is nothing to clear in storage.
//  A stalled output holds its register; the bank and the lanes fill behind
//  it and o_s_tready stays low while the lanes hold a tetrahedron.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_to_four_hex_split_top #(
    parameter int COORD_WIDTH = tthx_pkg::COORD_WIDTH_DEF,
    parameter int S_TDATA_W   = ((12 * COORD_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W   = ((5 + 3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z v3_x v3_y v3_z, zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // hex_index[2] corner_index[3] px py pz, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast
);
    import tthx_pkg::*;

    localparam int W = COORD_WIDTH;

    t_lane_ctl    w_ctl;
    t_lane_sts    w_sts [3];
    logic [W-1:0] w_v   [3][NUM_VERTS];
    logic [W-1:0] w_pts [3][NUM_POINTS];
    logic         w_accept;
    logic         w_load;
    logic         w_free;
    logic [1:0]   w_hex;
    logic [2:0]   w_corner;
    logic [W-1:0] w_px, w_py, w_pz;

    assign o_s_tready = w_sts[0].idle && w_sts[1].idle && w_sts[2].idle;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_free && w_sts[0].done && w_sts[1].done && w_sts[2].done;
    assign w_ctl      = '{start: w_accept, take: w_load};

    // One lane per axis
    for (genvar a = 0; a < 3; a++) begin : g_lane
        for (genvar k = 0; k < NUM_VERTS; k++) begin : g_vert
            assign w_v[a][k] = i_s_tdata[(k * 3 + a) * W +: W];
        end

        tthx_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_v     (w_v[a]),
            .o_sts   (w_sts[a]),
            .o_pts   (w_pts[a])
        );
    end

    tthx_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_pts_x  (w_pts[0]),
        .i_pts_y  (w_pts[1]),
        .i_pts_z  (w_pts[2]),
        .o_free   (w_free),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_hex    (w_hex),
        .o_corner (w_corner),
        .o_px     (w_px),
        .o_py     (w_py),
        .o_pz     (w_pz),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = M_TDATA_W'({w_pz, w_py, w_px, w_corner, w_hex});

    // The three lanes run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts[0] == w_sts[1]) && (w_sts[1] == w_sts[2]))
        else $error("axis lanes out of step");

    // An accepted tetrahedron closes the input until the lanes are released
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input open while lanes are busy");

    // The last flag sits on hexahedron 3, corner 7 only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == ((w_hex == 2'd3) && (w_corner == 3'd7))))
        else $error("last flag on wrong corner");

    // Points enter the bank only when it is empty or its last corner is leaving
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !w_free)
        else $error("bank not marked full after load");

endmodule

`default_nettype wire
